>>> src/mexp_pkg.sv
// Shared widths, constants and helpers for the modular exponentiation core.
`default_nettype none
package mexp_pkg;

    localparam int BASE_W = 30;
    localparam int EXP_W  = 63;
    localparam int RES_W  = 30;
    // Interleaved product needs two extra bits: 2r + a stays below 3p.
    localparam int WIDE_W = RES_W + 2;

    localparam logic [RES_W-1:0] PRIME   = 30'd1000000007;
    localparam logic [EXP_W-1:0] INV_EXP = 63'd1000000005;

    // One multiplier bit per cycle, most significant first.
    localparam int MUL_STEPS = RES_W;
    localparam int CNT_W     = $clog2(MUL_STEPS);

    function automatic logic [WIDE_W-1:0] sub_if_ge(input logic [WIDE_W-1:0] x);
        logic [WIDE_W-1:0] p_wide;
        p_wide = {2'b00, PRIME};
        return (x >= p_wide) ? (x - p_wide) : x;
    endfunction

endpackage
`default_nettype wire

>>> src/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
`default_nettype none
module mexp_mulmod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mexp_pkg::RES_W-1:0] a,
    input  logic [mexp_pkg::RES_W-1:0] b,
    output logic                       done,
    output logic [mexp_pkg::RES_W-1:0] product
);
    import mexp_pkg::*;

    logic [RES_W-1:0]  a_reg;
    logic [RES_W-1:0]  b_reg;
    logic [RES_W-1:0]  r_reg;
    logic [RES_W-1:0]  r_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WIDE_W-1:0] sum;
    logic [WIDE_W-1:0] sum_1;
    logic [WIDE_W-1:0] sum_2;

    // r = 2r + a*b_i, then fold back below p with at most two subtractions.
    always_comb
    begin
        sum = {1'b0, r_reg, 1'b0}
            + (b_reg[RES_W-1] ? {2'b00, a_reg} : {WIDE_W{1'b0}});
        sum_1  = sub_if_ge(sum);
        sum_2  = sub_if_ge(sum_1);
        r_next = sum_2[RES_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // Pulse done on the cycle after the last multiplier bit.
            done_reg <= !start && busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MUL_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            b_reg <= {b_reg[RES_W-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = r_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("done without a running multiply");

    a_product_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (r_reg < PRIME))
        else $error("product not reduced");

endmodule
`default_nettype wire

>>> src/modular_exponentiation_core.sv
// Top level: square-and-multiply exponentiation modulo 1000000007.
// One item at a time. The core scans the exponent from its low bit and, for each bit,
// runs the square and the conditional multiply on two bit-serial multipliers side by side;
// each multiply works through its operand one bit at a time.
// For an exponent whose bit length is L (0 for a zero exponent, up to 63), the core runs L
// such steps; a modular inverse request uses the exponent p-2, so L = 30.
// The input stalls while an item is at work; the finished residue sits
// in an output register, so the next item is taken while that residue waits to transfer.
`default_nettype none
module modular_exponentiation_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [mexp_pkg::BASE_W-1:0] base,
    input  logic [mexp_pkg::EXP_W-1:0]  exponent,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mexp_pkg::RES_W-1:0]  residue
);
    import mexp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [RES_W-1:0]  residue_reg;
    logic [RES_W-1:0]  acc_reg;
    logic [RES_W-1:0]  sq_reg;
    logic [EXP_W-1:0]  exp_reg;

    logic              in_xfer;
    logic              out_free;
    logic              fin_load;
    logic              mul_start;
    logic              done_acc;
    logic              done_sq;
    logic [RES_W-1:0]  prod_acc;
    logic [RES_W-1:0]  prod_sq;
    logic [WIDE_W-1:0] base_red;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign base_red = sub_if_ge({2'b00, base});

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        fin_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (exp_reg == '0)
                    state_next = S_FIN;
                else
                begin
                    mul_start  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (done_sq)
                    state_next = S_STEP;
            end
            S_FIN:
            begin
                // Hold the result until the output register is free.
                if (out_free)
                begin
                    fin_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = fin_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            acc_reg <= RES_W'(1);
            sq_reg  <= base_red[RES_W-1:0];
            exp_reg <= opcode ? INV_EXP : exponent;
        end
        else if (state_reg == S_MUL && done_sq)
        begin
            if (exp_reg[0])
                acc_reg <= prod_acc;
            sq_reg  <= prod_sq;
            exp_reg <= {1'b0, exp_reg[EXP_W-1:1]};
        end
        if (fin_load)
            residue_reg <= acc_reg;
    end

    mexp_mulmod u_mul_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (acc_reg),
        .b       (sq_reg),
        .done    (done_acc),
        .product (prod_acc)
    );

    mexp_mulmod u_mul_sq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (sq_reg),
        .b       (sq_reg),
        .done    (done_sq),
        .product (prod_sq)
    );

    assign out_valid = out_valid_reg;
    assign residue   = residue_reg;

    a_units_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        done_acc == done_sq)
        else $error("multipliers out of step");

    a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        done_sq |-> (state_reg == S_MUL))
        else $error("multiply finished outside the multiply state");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall && (state_reg == S_STEP))
        else $error("item taken but core not running");

    a_exp_done_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP && exp_reg == '0) |=> (state_reg == S_FIN))
        else $error("exhausted exponent did not finish");

    a_residue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (residue_reg < PRIME))
        else $error("residue not reduced");

endmodule
`default_nettype wire
